[rtl/assert_macros.svh]
// Assertion macros used by the controller core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define PHC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define PHC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/phc_pkg.sv]
// Types, constants, microcode and Q16.16 helpers for the PID heater controller.
package phc_pkg;

    localparam int HISTORY_LEN_DEF = 8;

    // Full drive band; zero means no band
    localparam logic [30:0] FULL_DRIVE_BAND = 31'd0;

    localparam logic signed [32:0] HALF_Q16     = 33'sd32768;
    localparam logic [31:0]        DRIVE_MAX_RST = 32'd6553600;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SETPOINT    = 3'd0;
    localparam cfg_idx_t CFG_GAIN_P      = 3'd1;
    localparam cfg_idx_t CFG_GAIN_I      = 3'd2;
    localparam cfg_idx_t CFG_GAIN_D      = 3'd3;
    localparam cfg_idx_t CFG_DRIVE_MIN   = 3'd4;
    localparam cfg_idx_t CFG_DRIVE_MAX   = 3'd5;
    localparam cfg_idx_t CFG_INT_LIMIT   = 3'd6;
    localparam cfg_idx_t CFG_FEEDFORWARD = 3'd7;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ERR,
        OP_HIST,
        OP_INTEG,
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_D,
        OP_ACC_I,
        OP_ACC_D,
        OP_CLAMP,
        OP_BANG,
        OP_SCAN0,
        OP_SCAN,
        OP_EMIT
    } op_t;

    // Hold on the current step while the condition stands
    typedef enum logic [1:0] {
        W_NONE,
        W_INPUT,
        W_OUTPUT
    } stall_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_SP_ZERO,
        C_OUTSIDE,
        C_SCAN_MORE
    } cond_t;

    typedef logic [3:0] step_t;
    localparam step_t ST_WAIT  = 4'd0;
    localparam step_t ST_ERR   = 4'd1;
    localparam step_t ST_HIST  = 4'd2;
    localparam step_t ST_INTEG = 4'd3;
    localparam step_t ST_MUL_P = 4'd4;
    localparam step_t ST_MUL_I = 4'd5;
    localparam step_t ST_MUL_D = 4'd6;
    localparam step_t ST_ACC_I = 4'd7;
    localparam step_t ST_ACC_D = 4'd8;
    localparam step_t ST_CLAMP = 4'd9;
    localparam step_t ST_BANG  = 4'd10;
    localparam step_t ST_SCAN0 = 4'd11;
    localparam step_t ST_SCAN  = 4'd12;
    localparam step_t ST_EMIT  = 4'd13;

    typedef struct packed {
        op_t    op;
        stall_t stall;
        cond_t  cond;
        step_t  target;
    } uword_t;

    // Control store
    function automatic uword_t ucode_rom(step_t pc);
        uword_t w;
        unique case (pc)
            ST_WAIT:  w = '{OP_LOAD,  W_INPUT,  C_NEXT,      ST_WAIT};
            ST_ERR:   w = '{OP_ERR,   W_NONE,   C_SP_ZERO,   ST_SCAN0};
            ST_HIST:  w = '{OP_HIST,  W_NONE,   C_NEXT,      ST_WAIT};
            ST_INTEG: w = '{OP_INTEG, W_NONE,   C_OUTSIDE,   ST_BANG};
            ST_MUL_P: w = '{OP_MUL_P, W_NONE,   C_NEXT,      ST_WAIT};
            ST_MUL_I: w = '{OP_MUL_I, W_NONE,   C_NEXT,      ST_WAIT};
            ST_MUL_D: w = '{OP_MUL_D, W_NONE,   C_NEXT,      ST_WAIT};
            ST_ACC_I: w = '{OP_ACC_I, W_NONE,   C_NEXT,      ST_WAIT};
            ST_ACC_D: w = '{OP_ACC_D, W_NONE,   C_NEXT,      ST_WAIT};
            ST_CLAMP: w = '{OP_CLAMP, W_NONE,   C_ALWAYS,    ST_SCAN0};
            ST_BANG:  w = '{OP_BANG,  W_NONE,   C_NEXT,      ST_WAIT};
            ST_SCAN0: w = '{OP_SCAN0, W_NONE,   C_NEXT,      ST_WAIT};
            ST_SCAN:  w = '{OP_SCAN,  W_NONE,   C_SCAN_MORE, ST_SCAN};
            ST_EMIT:  w = '{OP_EMIT,  W_OUTPUT, C_ALWAYS,    ST_WAIT};
            default:  w = '{OP_NOP,   W_NONE,   C_ALWAYS,    ST_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic signed [31:0] sat33(logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -33'sd2147483648) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        return sat33(33'(a) + 33'(b));
    endfunction

    function automatic logic signed [31:0] sat_sub(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        return sat33(33'(a) - 33'(b));
    endfunction

    // Q16.16 product scaling, half away from zero, saturated
    function automatic logic signed [31:0] q_round(logic signed [63:0] p);
        logic signed [63:0] t;
        logic signed [31:0] r;
        t = p + (p[63] ? 64'sd32767 : 64'sd32768);
        t = t >>> 16;
        if (t > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (t < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = t[31:0];
        end
        return r;
    endfunction

    // Low bound first, then high bound (high wins if the bounds cross)
    function automatic logic signed [31:0] q_clamp(logic signed [31:0] x,
                                                   logic signed [31:0] lo,
                                                   logic signed [31:0] hi);
        logic signed [31:0] r;
        r = (x < lo) ? lo : x;
        r = (r > hi) ? hi : r;
        return r;
    endfunction

endpackage

[rtl/pid_heater_controller_q16_core.sv]
// Q16.16 PID heater controller: microcoded sequencer and datapath.
//
// Use: one measurement request on the input channel (in_valid/in_ready) gives
// one result request (drive, stable) on the output channel (out_valid/out_ready).
// The gains, limits, setpoint and feedforward term sit on a plain write port
// (cfg_write, cfg_index, cfg_data) and are to be written while the block is
// idle; the block does not enforce this. A request is taken only while the
// sequencer sits on its wait step; it then runs a micro-program: error,
// history update, integral, three products through one shared 32x32
// multiplier, clamp, then a scan of the history. A zero setpoint jumps from
// error straight to the scan; an error outside a nonzero full drive band
// gives bang-bang drive in place of the products and clamp. No new request
// is taken until the program is back on its wait step; the history scan
// through the single memory read port and the shared multiplier set its length.
// The result sits in an output register, so the next measurement is taken
// while the last result waits; a stalled receiver holds the sequencer on its
// final step only when a second result is ready to go.
// Reset clears the configuration to its defaults, the integral, the head
// pointer and the per-entry valid bits of the history (an entry not yet
// written reads as zero); no clearing pass is needed.

`include "assert_macros.svh"

module pid_heater_controller_q16_core #(
    parameter int HISTORY_LEN = phc_pkg::HISTORY_LEN_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [31:0]      measurement,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [31:0]      drive,
    output logic                    stable,
    input  logic                    cfg_write,
    input  phc_pkg::cfg_idx_t       cfg_index,
    input  logic [31:0]             cfg_data
);
    import phc_pkg::*;

    localparam int IDX_W = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam int CNT_W = $clog2(HISTORY_LEN + 1);
    localparam logic [IDX_W-1:0] HEAD_LAST = IDX_W'(HISTORY_LEN - 1);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(HISTORY_LEN - 1);

    // Configuration registers
    logic signed [31:0] setpoint_reg;
    logic signed [31:0] gain_p_reg;
    logic signed [31:0] gain_i_reg;
    logic signed [31:0] gain_d_reg;
    logic signed [31:0] drive_min_reg;
    logic signed [31:0] drive_max_reg;
    logic [30:0]        int_limit_reg;
    logic signed [31:0] feedforward_reg;

    // Sequencer
    step_t  pc_reg, pc_next;
    uword_t uw;
    logic   take_jump;
    logic   stall;
    logic   out_busy;

    // Datapath registers
    logic signed [31:0] x_reg,     x_next;
    logic signed [31:0] err_reg,   err_next;
    logic signed [31:0] din_reg,   din_next;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [31:0] acc_reg,   acc_next;
    logic signed [63:0] prod_reg,  prod_next;
    logic signed [31:0] qm_reg,    qm_next;
    logic signed [31:0] drv_reg,   drv_next;
    logic               stab_reg,  stab_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [IDX_W-1:0]   head_reg,  head_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] drive_reg,     drive_next;
    logic               stable_reg,    stable_next;

    // Sample memory with per-entry valid bits
    logic signed [31:0]    hist_mem [HISTORY_LEN];
    logic [HISTORY_LEN-1:0] hvalid_reg, hvalid_next;
    logic [IDX_W-1:0]      rd_addr;
    logic signed [31:0]    rdata_reg;
    logic                  rvalid_reg;
    logic signed [31:0]    rd_sample;
    logic                  mem_we;

    // Shared multiplier
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;

    // Misc datapath terms
    logic [32:0]        err_abs;
    logic               outside;
    logic signed [31:0] lim_pos;
    logic signed [31:0] lim_neg;
    logic signed [32:0] scan_diff;
    logic               scan_off;
    logic [CNT_W-1:0]   cnt_inc;
    logic               emit_fire;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg    <= '0;
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            drive_min_reg   <= '0;
            drive_max_reg   <= DRIVE_MAX_RST;
            int_limit_reg   <= '0;
            feedforward_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SETPOINT:    setpoint_reg    <= cfg_data;
                CFG_GAIN_P:      gain_p_reg      <= cfg_data;
                CFG_GAIN_I:      gain_i_reg      <= cfg_data;
                CFG_GAIN_D:      gain_d_reg      <= cfg_data;
                CFG_DRIVE_MIN:   drive_min_reg   <= cfg_data;
                CFG_DRIVE_MAX:   drive_max_reg   <= cfg_data;
                CFG_INT_LIMIT:   int_limit_reg   <= cfg_data[30:0];
                CFG_FEEDFORWARD: feedforward_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: control store, stall, conditional jump
    // ---------------------------------------------------------------
    assign uw       = ucode_rom(pc_reg);
    assign out_busy = out_valid_reg && !out_ready;

    // Band test on the error: only taken for a positive band
    assign err_abs = err_reg[31] ? (33'd0 - {err_reg[31], err_reg}) : {1'b0, err_reg};
    assign outside = (FULL_DRIVE_BAND != '0) && (err_abs > {2'b00, FULL_DRIVE_BAND});

    always_comb
    begin
        case (uw.stall)
            W_INPUT:  stall = !in_valid;
            W_OUTPUT: stall = out_busy;
            default:  stall = 1'b0;
        endcase

        unique case (uw.cond)
            C_ALWAYS:    take_jump = 1'b1;
            C_SP_ZERO:   take_jump = (setpoint_reg == '0);
            C_OUTSIDE:   take_jump = outside;
            C_SCAN_MORE: take_jump = (cnt_reg != CNT_LAST);
            default:     take_jump = 1'b0;
        endcase

        if (stall)
        begin
            pc_next = pc_reg;
        end
        else if (take_jump)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + 4'd1;
        end
    end

    assign in_ready  = (uw.stall == W_INPUT);
    assign emit_fire = (uw.op == OP_EMIT) && !out_busy;

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    assign rd_sample = rvalid_reg ? rdata_reg : 32'sd0;
    assign lim_pos   = $signed({1'b0, int_limit_reg});
    assign lim_neg   = 32'sd0 - lim_pos;
    assign scan_diff = 33'(rd_sample) - 33'(setpoint_reg);
    assign scan_off  = (scan_diff > HALF_Q16) || (scan_diff < -HALF_Q16);
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign mem_we    = (uw.op == OP_HIST);

    // Operand select for the one multiplier
    always_comb
    begin
        case (uw.op)
            OP_MUL_I:
            begin
                mul_a = gain_i_reg;
                mul_b = integ_reg;
            end
            OP_MUL_D:
            begin
                mul_a = gain_d_reg;
                mul_b = din_reg;
            end
            default:
            begin
                mul_a = gain_p_reg;
                mul_b = err_reg;
            end
        endcase
    end

    // Memory read address
    always_comb
    begin
        case (uw.op)
            OP_SCAN0: rd_addr = '0;
            OP_SCAN:  rd_addr = (cnt_reg == CNT_LAST) ? '0 : cnt_inc[IDX_W-1:0];
            default:  rd_addr = head_reg;
        endcase
    end

    always_comb
    begin
        x_next      = x_reg;
        err_next    = err_reg;
        din_next    = din_reg;
        integ_next  = integ_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        qm_next     = qm_reg;
        drv_next    = drv_reg;
        stab_next   = stab_reg;
        cnt_next    = cnt_reg;
        head_next   = head_reg;
        hvalid_next = hvalid_reg;

        unique case (uw.op)
            OP_LOAD:
            begin
                if (in_valid)
                begin
                    x_next = measurement;
                end
            end
            OP_ERR:
            begin
                err_next = sat_sub(setpoint_reg, x_reg);
                drv_next = '0;
            end
            OP_HIST:
            begin
                // rd_sample holds the entry being replaced
                din_next              = sat_sub(x_reg, rd_sample);
                hvalid_next[head_reg] = 1'b1;
                head_next             = (head_reg == HEAD_LAST) ? '0 : head_reg + IDX_W'(1);
            end
            OP_INTEG:
            begin
                integ_next = outside ? 32'sd0
                           : q_clamp(sat_add(integ_reg, err_reg), lim_neg, lim_pos);
                acc_next   = feedforward_reg;
            end
            OP_MUL_P:
            begin
                prod_next = mul_a * mul_b;
            end
            OP_MUL_I:
            begin
                qm_next   = q_round(prod_reg);
                prod_next = mul_a * mul_b;
            end
            OP_MUL_D:
            begin
                acc_next  = sat_add(acc_reg, qm_reg);
                qm_next   = q_round(prod_reg);
                prod_next = mul_a * mul_b;
            end
            OP_ACC_I:
            begin
                acc_next = sat_add(acc_reg, qm_reg);
                qm_next  = q_round(prod_reg);
            end
            OP_ACC_D:
            begin
                acc_next = sat_sub(acc_reg, qm_reg);
            end
            OP_CLAMP:
            begin
                drv_next = q_clamp(acc_reg, drive_min_reg, drive_max_reg);
            end
            OP_BANG:
            begin
                drv_next = (err_reg > 32'sd0) ? drive_max_reg : drive_min_reg;
            end
            OP_SCAN0:
            begin
                cnt_next  = '0;
                stab_next = 1'b1;
            end
            OP_SCAN:
            begin
                if (scan_off)
                begin
                    stab_next = 1'b0;
                end
                if (cnt_reg != CNT_LAST)
                begin
                    cnt_next = cnt_inc;
                end
            end
            default: ;
        endcase
    end

    // Output register: a new result may load as the old one leaves
    always_comb
    begin
        out_valid_next = out_valid_reg;
        drive_next     = drive_reg;
        stable_next    = stable_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            drive_next     = drv_reg;
            stable_next    = stab_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ST_WAIT;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            head_reg      <= '0;
            hvalid_reg    <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
            head_reg      <= head_next;
            hvalid_reg    <= hvalid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        err_reg    <= err_next;
        din_reg    <= din_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        qm_reg     <= qm_next;
        drv_reg    <= drv_next;
        stab_reg   <= stab_next;
        drive_reg  <= drive_next;
        stable_reg <= stable_next;
    end

    // Sample memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[head_reg] <= x_reg;
        end
        rdata_reg  <= hist_mem[rd_addr];
        rvalid_reg <= hvalid_reg[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign stable    = stable_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `PHC_ASSERT(a_accept_goes_to_err, (in_valid && in_ready) |=> (pc_reg == ST_ERR),
        "accepted request did not start the error step")
    `PHC_ASSERT(a_result_from_emit, $rose(out_valid) |-> $past(pc_reg == ST_EMIT),
        "result offered outside the emit step")
    `PHC_ASSERT(a_head_moves_on_hist, (head_reg != $past(head_reg)) |-> $past(pc_reg == ST_HIST),
        "history head moved outside the history step")
    `PHC_ASSERT(a_emit_holds_when_busy,
        (pc_reg == ST_EMIT && out_valid && !out_ready) |=> ($stable(drive) && pc_reg == ST_EMIT),
        "pending result overwritten while receiver stalled")

endmodule

[sim/phc_drive_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the PID heater controller: predicts each drive/stable result and checks it.
module phc_drive_checker #(
    parameter int HISTORY_LEN = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic signed [31:0]  measurement,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic signed [31:0]  drive,
    input  logic                stable,
    input  logic                cfg_write,
    input  phc_pkg::cfg_idx_t   cfg_index,
    input  logic [31:0]         cfg_data,
    output int                  fail_count,
    output int                  results_pending
);

    import phc_pkg::*;

    localparam longint HALF_UNIT  = 64'sd32768;
    // Full drive band; zero disables the bang-bang path
    localparam longint DRIVE_BAND = 64'sd0;

    typedef struct {
        logic signed [31:0] drive;
        logic               stable;
    } drive_result_t;

    logic signed [31:0] setpoint;
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic signed [31:0] drive_lo;
    logic signed [31:0] drive_hi;
    logic [30:0]        integ_limit;
    logic signed [31:0] feedforward;

    logic signed [31:0] samples [HISTORY_LEN];
    int                 head;
    logic signed [31:0] integral;

    drive_result_t      awaited [$];
    int                 n_fail = 0;

    assign fail_count = n_fail;

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

    // Q16.16 product, rounded half away from zero
    function automatic logic signed [31:0] fx_mul(logic signed [31:0] a,
                                                  logic signed [31:0] b);
        longint prod;
        longint mag;
        longint rounded;
        prod    = longint'(a) * longint'(b);
        mag     = (prod < 0) ? -prod : prod;
        rounded = (mag + HALF_UNIT) >>> 16;
        return sat32((prod < 0) ? -rounded : rounded);
    endfunction

    // Low bound applied first, so crossed bounds give the high one
    function automatic logic signed [31:0] bound(logic signed [31:0] x,
                                                 logic signed [31:0] lo,
                                                 logic signed [31:0] hi);
        logic signed [31:0] r;
        r = (x < lo) ? lo : x;
        r = (r > hi) ? hi : r;
        return r;
    endfunction

    function automatic drive_result_t pid_step(logic signed [31:0] x);
        logic signed [31:0] err;
        logic signed [31:0] oldest;
        logic signed [31:0] delta;
        logic signed [31:0] acc;
        logic signed [31:0] lim;
        longint             dev;
        drive_result_t      res;
        res.drive  = '0;
        res.stable = 1'b1;
        if (setpoint != 0) begin
            err           = sat32(longint'(setpoint) - longint'(x));
            oldest        = samples[head];
            samples[head] = x;
            head          = (head + 1) % HISTORY_LEN;
            delta         = sat32(longint'(x) - longint'(oldest));
            if (DRIVE_BAND > 0 &&
                ((err < 0) ? -longint'(err) : longint'(err)) > DRIVE_BAND) begin
                integral  = '0;
                res.drive = (err > 0) ? drive_hi : drive_lo;
            end
            else begin
                lim       = $signed({1'b0, integ_limit});
                integral  = bound(sat32(longint'(integral) + longint'(err)), -lim, lim);
                acc       = sat32(longint'(feedforward) + longint'(fx_mul(gain_p, err)));
                acc       = sat32(longint'(acc) + longint'(fx_mul(gain_i, integral)));
                acc       = sat32(longint'(acc) - longint'(fx_mul(gain_d, delta)));
                res.drive = bound(acc, drive_lo, drive_hi);
            end
        end
        foreach (samples[i]) begin
            dev = longint'(samples[i]) - longint'(setpoint);
            if (dev > HALF_UNIT || dev < -HALF_UNIT) begin
                res.stable = 1'b0;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin : monitor
        drive_result_t want;
        if (!rst_n) begin
            setpoint    = '0;
            gain_p      = '0;
            gain_i      = '0;
            gain_d      = '0;
            drive_lo    = '0;
            drive_hi    = 32'sd6553600;
            integ_limit = '0;
            feedforward = '0;
            foreach (samples[i]) begin
                samples[i] = '0;
            end
            head     = 0;
            integral = '0;
            awaited.delete();
            results_pending <= 0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_SETPOINT:    setpoint    = cfg_data;
                    CFG_GAIN_P:      gain_p      = cfg_data;
                    CFG_GAIN_I:      gain_i      = cfg_data;
                    CFG_GAIN_D:      gain_d      = cfg_data;
                    CFG_DRIVE_MIN:   drive_lo    = cfg_data;
                    CFG_DRIVE_MAX:   drive_hi    = cfg_data;
                    CFG_INT_LIMIT:   integ_limit = cfg_data[30:0];
                    CFG_FEEDFORWARD: feedforward = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                awaited.push_back(pid_step(measurement));
            end
            if (out_valid && out_ready) begin
                if (awaited.size() == 0) begin
                    $error("unexpected result: drive %0d stable %0b", drive, stable);
                    n_fail = n_fail + 1;
                end
                else begin
                    want = awaited.pop_front();
                    if (drive !== want.drive) begin
                        $error("drive: expected %0d, actual %0d", want.drive, drive);
                        n_fail = n_fail + 1;
                    end
                    if (stable !== want.stable) begin
                        $error("stable: expected %0b, actual %0b", want.stable, stable);
                        n_fail = n_fail + 1;
                    end
                end
            end
            results_pending <= awaited.size();
        end
    end

endmodule

[sim/tb_pid_heater_controller_q16_core.sv]
`timescale 1ns / 100ps
// Testbench top for the PID heater controller: stimulus, idling, watchdog and verdict.
module tb_pid_heater_controller_q16_core;

    import phc_pkg::*;

    localparam int HISTORY_LEN = HISTORY_LEN_DEF;
    // Acceptance to result offered, nonzero setpoint
    localparam int LATENCY     = HISTORY_LEN + 11;
    // Cycles with no request moving and no register write before the run is abandoned
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 100;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic signed [31:0] measurement = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic signed [31:0] drive;
    logic               stable;
    logic               cfg_write   = 1'b0;
    cfg_idx_t           cfg_index   = CFG_SETPOINT;
    logic [31:0]        cfg_data    = '0;

    int                 fail_count;
    int                 results_pending;
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    int                 quiet_cycles = 0;
    logic signed [31:0] cur_sp = '0;

    pid_heater_controller_q16_core #(
        .HISTORY_LEN (HISTORY_LEN)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive       (drive),
        .stable      (stable),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    phc_drive_checker #(
        .HISTORY_LEN (HISTORY_LEN)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .measurement     (measurement),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .drive           (drive),
        .stable          (stable),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver back-pressure: a fresh coin every cycle at the current idle rate
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: any request moving on either channel, or a register write,
    // counts as progress. A hung block ends the run here.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Sum with saturation, so offsets near the rails stay in range
    function automatic logic [31:0] offset_sample(logic signed [31:0] centre, longint offs);
        longint v;
        v = longint'(centre) + offs;
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
        end
        return 32'(v);
    endfunction

    // Sample classes: mostly within about half a unit of the setpoint, so
    // runs of them fill the history and the stable flag actually rises;
    // the rest are wider swings, rail values and raw noise.
    function automatic logic [31:0] draw_sample(int kind);
        logic [31:0] v;
        if (kind <= 5) begin
            v = offset_sample(cur_sp, longint'($urandom_range(0, 32'h1_0800)) - 64'sh8400);
        end
        else if (kind <= 7) begin
            v = offset_sample(cur_sp, longint'($urandom_range(0, 32'h10_0000)) - 64'sh8_0000);
        end
        else if (kind == 8) begin
            case ($urandom_range(3))
                0:       v = 32'h7FFF_FFFF;
                1:       v = 32'h8000_0000;
                2:       v = 32'h0000_0000;
                default: v = cur_sp;
            endcase
        end
        else begin
            v = $urandom;
        end
        return v;
    endfunction

    // Gains and feedforward: small Q16.16 values half the time, else rails, zero or noise
    function automatic logic [31:0] draw_gain();
        logic [31:0] v;
        case ($urandom_range(9))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = 32'h0000_0000;
            3, 4:    v = $urandom;
            default: v = 32'(longint'($urandom_range(0, 32'h8_0000)) - 64'sh4_0000);
        endcase
        return v;
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic program_all(logic [31:0] sp, logic [31:0] kp, logic [31:0] ki,
                               logic [31:0] kd, logic [31:0] lo, logic [31:0] hi,
                               logic [31:0] ilim, logic [31:0] ff);
        write_reg(CFG_SETPOINT, sp);
        write_reg(CFG_GAIN_P, kp);
        write_reg(CFG_GAIN_I, ki);
        write_reg(CFG_GAIN_D, kd);
        write_reg(CFG_DRIVE_MIN, lo);
        write_reg(CFG_DRIVE_MAX, hi);
        write_reg(CFG_INT_LIMIT, ilim);
        write_reg(CFG_FEEDFORWARD, ff);
        cur_sp = sp;
    endtask

    // Valid is only lowered when a gap is taken, so a back-to-back request
    // never sees valid dropped and raised in the same step.
    task automatic send_measurement(logic [31:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        measurement <= value;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop sending, let the checker count the last accepted request, then wait
    // for every outstanding result.
    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (results_pending == 0);
    endtask

    task automatic randomise_settings();
        logic [31:0] sp;
        logic [31:0] ilim;
        longint      lo;
        longint      hi;
        case ($urandom_range(9))
            0:       sp = 32'h0;
            1:       sp = $urandom;
            default: sp = 32'(longint'($urandom_range(0, 400 << 16)) - (64'sd200 << 16));
        endcase
        lo = longint'($urandom_range(0, 200 << 16)) - (64'sd100 << 16);
        case ($urandom_range(4))
            0: begin
                lo = -64'sd2147483648;
                hi = 64'sd2147483647;
            end
            // crossed limits
            1:       hi = lo - longint'($urandom_range(1, 50 << 16));
            default: hi = lo + longint'($urandom_range(0, 200 << 16));
        endcase
        case ($urandom_range(5))
            0:       ilim = 32'h0;
            1:       ilim = 32'hFFFF_FFFF;
            2:       ilim = $urandom;
            default: ilim = $urandom_range(0, 500 << 16);
        endcase
        program_all(sp, draw_gain(), draw_gain(), draw_gain(), 32'(lo), 32'(hi),
                    ilim, draw_gain());
    endtask

    initial begin : stimulus
        int phase;
        int n;
        int run_left;
        int run_kind;
        run_left = 0;
        run_kind = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 16;
        rx_idle_pct = 73;

        // Settings straight out of reset: zero setpoint, so drive is zero and
        // nothing is stored; rails on the measurement.
        send_measurement(32'h7FFF_FFFF);
        send_measurement(32'h8000_0000);
        settle_block();

        // Ordinary loop: setpoint 50.0, drive 0..100.0. Samples on both edges
        // of the half-unit window fill the history until stable rises, one
        // step just outside drops it, then the rails saturate error and delta.
        program_all(32'h0032_0000, 32'h0002_0000, 32'h0000_4000, 32'h0001_0000,
                    32'h0000_0000, 32'h0064_0000, 32'h00C8_0000, 32'h000A_0000);
        send_measurement(32'h0031_8000);
        send_measurement(32'h0032_8000);
        repeat (6) send_measurement(32'h0032_0000);
        send_measurement(32'h0032_8001);
        send_measurement(32'h7FFF_FFFF);
        send_measurement(32'h8000_0000);
        settle_block();

        // Every register at a rail; integral limit written with bit 31 set
        program_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_measurement(32'h7FFF_FFFF);
        send_measurement(32'h0000_0000);
        send_measurement(32'hFFFF_FFFF);
        settle_block();

        // Crossed drive limits (min 100.0, max -100.0) and the other rails
        program_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h0064_0000, 32'hFF9C_0000, 32'h0000_0000, 32'h8000_0000);
        send_measurement(32'h8000_0000);
        send_measurement(32'h7FFF_FFFF);
        settle_block();

        // Back to a zero setpoint with a full history: state frozen, stable
        // judged against zero
        write_reg(CFG_SETPOINT, 32'h0);
        cur_sp = '0;
        send_measurement(32'h1234_5678);
        send_measurement(32'h0000_0000);
        settle_block();

        // Random part: fresh settings per phase, samples in runs of one class
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < PHASES / 3) begin
                tx_idle_pct = 16;
                rx_idle_pct = 73;
            end
            else if (phase < 2 * PHASES / 3) begin
                tx_idle_pct = 73;
                rx_idle_pct = 16;
            end
            else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            randomise_settings();
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (run_left == 0) begin
                    run_kind = $urandom_range(9);
                    run_left = $urandom_range(1, 12);
                end
                run_left--;
                send_measurement(draw_sample(run_kind));
            end
            settle_block();
        end

        // Let any stray result show itself before the verdict
        repeat (LATENCY) @(posedge clk);
        if (fail_count == 0) begin
            $display("PASS");
        end
        else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/phc_pkg.sv
rtl/pid_heater_controller_q16_core.sv
sim/phc_drive_checker.sv
sim/tb_pid_heater_controller_q16_core.sv
